// ===== hdl/blg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package blg_pkg;

	// Width of the colour field carried on every pixel
	localparam int COLOUR_BITS = 8;

	// Command codes on the input word
	typedef enum logic {
		CMD_START = 1'b0,
		CMD_STEP  = 1'b1
	} cmd_kind_t;

	// Classification the front end attaches to each queued word
	typedef struct packed {
		cmd_kind_t kind;
		logic      steep;       // major axis is y
		logic      minor_down;  // minor coordinate decreases along the line
	} blg_class_t;

endpackage

`default_nettype wire

// ===== hdl/blg_cmd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface blg_cmd_if #(
	parameter int COORD_BITS = 10
);
	import blg_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   cmd;
	logic [COORD_BITS-1:0]  x_start;
	logic [COORD_BITS-1:0]  y_start;
	logic [COORD_BITS-1:0]  x_end;
	logic [COORD_BITS-1:0]  y_end;
	logic [COLOUR_BITS-1:0] colour;

	modport source (
		output valid, cmd, x_start, y_start, x_end, y_end, colour,
		input  ready
	);

	modport sink (
		input  valid, cmd, x_start, y_start, x_end, y_end, colour,
		output ready
	);

endinterface

`default_nettype wire

// ===== hdl/blg_pix_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface blg_pix_if #(
	parameter int COORD_BITS = 10
);
	import blg_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [COORD_BITS-1:0]  pixel_x;
	logic [COORD_BITS-1:0]  pixel_y;
	logic [COLOUR_BITS-1:0] pixel_colour;
	logic                   last_pixel;

	modport source (
		output valid, pixel_x, pixel_y, pixel_colour, last_pixel,
		input  ready
	);

	modport sink (
		input  valid, pixel_x, pixel_y, pixel_colour, last_pixel,
		output ready
	);

endinterface

`default_nettype wire

// ===== hdl/blg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Front end: takes command words, sorts endpoints onto major/minor axes
module blg_front #(
	parameter int COORD_BITS = 10
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	blg_cmd_if.sink                              cmds,
	output logic                                 f_valid,
	input  wire logic                            f_ready,
	output blg_pkg::blg_class_t                  f_cls,
	output logic [COORD_BITS-1:0]                f_ma0,
	output logic [COORD_BITS-1:0]                f_ma1,
	output logic [COORD_BITS-1:0]                f_mi0,
	output logic [COORD_BITS-1:0]                f_dmaj,
	output logic [COORD_BITS-1:0]                f_dmin,
	output logic [blg_pkg::COLOUR_BITS-1:0]      f_colour
);
	import blg_pkg::*;

	logic [COORD_BITS:0]    dx_w, dy_w;
	logic [COORD_BITS-1:0]  adx, ady;
	logic                   x_lt, x_gt, y_lt, y_gt;
	logic                   steep, swap, min_lt, min_gt;
	logic [COORD_BITS-1:0]  ma0, ma1, mi0, mi1;
	logic                   accept;
	blg_class_t             cls;

	logic                   valid_s1;
	blg_class_t             cls_s1;
	logic [COORD_BITS-1:0]  ma0_s1, ma1_s1, mi0_s1, dmaj_s1, dmin_s1;
	logic [COLOUR_BITS-1:0] colour_s1;

	// Signed differences and magnitudes of both axes
	always_comb begin
		dx_w = {1'b0, cmds.x_end} - {1'b0, cmds.x_start};
		dy_w = {1'b0, cmds.y_end} - {1'b0, cmds.y_start};
		x_lt = dx_w[COORD_BITS];
		y_lt = dy_w[COORD_BITS];
		x_gt = !x_lt && (cmds.x_end != cmds.x_start);
		y_gt = !y_lt && (cmds.y_end != cmds.y_start);
		adx  = x_lt ? COORD_BITS'(~dx_w + 1'b1) : dx_w[COORD_BITS-1:0];
		ady  = y_lt ? COORD_BITS'(~dy_w + 1'b1) : dy_w[COORD_BITS-1:0];
	end

	// Axis selection; endpoints swapped so the major axis ascends
	always_comb begin
		steep  = ady > adx;
		swap   = steep ? y_lt : x_lt;
		min_lt = steep ? x_lt : y_lt;
		min_gt = steep ? x_gt : y_gt;
		ma0    = steep ? cmds.y_start : cmds.x_start;
		ma1    = steep ? cmds.y_end   : cmds.x_end;
		mi0    = steep ? cmds.x_start : cmds.y_start;
		mi1    = steep ? cmds.x_end   : cmds.y_end;
		if (swap) begin
			ma0 = steep ? cmds.y_end   : cmds.x_end;
			ma1 = steep ? cmds.y_start : cmds.x_start;
			mi0 = mi1;
		end
		cls.kind       = cmd_kind_t'(cmds.cmd);
		cls.steep      = steep;
		cls.minor_down = swap ? min_gt : min_lt;
	end

	assign cmds.ready = !valid_s1 || f_ready;
	assign accept     = cmds.valid && cmds.ready;

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (f_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cls_s1    <= cls;
			ma0_s1    <= ma0;
			ma1_s1    <= ma1;
			mi0_s1    <= mi0;
			dmaj_s1   <= steep ? ady : adx;
			dmin_s1   <= steep ? adx : ady;
			colour_s1 <= cmds.colour;
		end
	end

	assign f_valid  = valid_s1;
	assign f_cls    = cls_s1;
	assign f_ma0    = ma0_s1;
	assign f_ma1    = ma1_s1;
	assign f_mi0    = mi0_s1;
	assign f_dmaj   = dmaj_s1;
	assign f_dmin   = dmin_s1;
	assign f_colour = colour_s1;

endmodule

`default_nettype wire

// ===== hdl/blg_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Small register FIFO between front and back end
module blg_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [WIDTH-1:0] in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [WIDTH-1:0]      out_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push, pop;

	assign in_ready  = count_q != CW'(DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/blg_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Back end: line set-up, per-pixel stepping and the output register
module blg_back #(
	parameter int COORD_BITS = 10
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                b_valid,
	output logic                                     b_ready,
	input  wire blg_pkg::blg_class_t                 b_cls,
	input  wire logic [COORD_BITS-1:0]               b_ma0,
	input  wire logic [COORD_BITS-1:0]               b_ma1,
	input  wire logic [COORD_BITS-1:0]               b_mi0,
	input  wire logic [COORD_BITS-1:0]               b_dmaj,
	input  wire logic [COORD_BITS-1:0]               b_dmin,
	input  wire logic [blg_pkg::COLOUR_BITS-1:0]     b_colour,
	blg_pix_if.source                                pixels
);
	import blg_pkg::*;

	localparam int EW = COORD_BITS + 3;  // error and diagonal increment, signed
	localparam int SW = COORD_BITS + 2;  // straight increment

	// Line state
	logic                   active_q;
	logic [COORD_BITS-1:0]  major_q, end_q, minor_q;
	logic [EW-1:0]          err_q, diag_q;
	logic [SW-1:0]          straight_q;
	logic                   down_q, steep_q;
	logic [COLOUR_BITS-1:0] colour_q;

	// Output register
	logic                   out_valid_q;
	logic [COORD_BITS-1:0]  px_q, py_q;
	logic [COLOUR_BITS-1:0] pc_q;
	logic                   last_q;

	logic                   pop, is_start, do_step;
	logic [EW-1:0]          err0, diag0;
	logic                   last0;
	logic [COORD_BITS-1:0]  major_n, minor_n;
	logic [EW-1:0]          err_n;
	logic                   last_n;

	assign b_ready  = !out_valid_q || pixels.ready;
	assign pop      = b_valid && b_ready;
	assign is_start = b_cls.kind == CMD_START;
	assign do_step  = pop && !is_start && active_q;

	// Set-up terms of a new line
	always_comb begin
		err0  = {2'b00, b_dmin, 1'b0} - {3'b000, b_dmaj};
		diag0 = {2'b00, b_dmin, 1'b0} - {2'b00, b_dmaj, 1'b0};
		last0 = b_ma0 == b_ma1;
	end

	// One step: major advances, minor follows when the error is not negative
	always_comb begin
		major_n = major_q + 1'b1;
		if (!err_q[EW-1]) begin
			minor_n = down_q ? minor_q - 1'b1 : minor_q + 1'b1;
			err_n   = err_q + diag_q;
		end else begin
			minor_n = minor_q;
			err_n   = err_q + {1'b0, straight_q};
		end
		last_n = major_n == end_q;
	end

	// Control flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (pop) begin
			unique case (b_cls.kind)
				CMD_START: begin
					active_q    <= !last0;
					out_valid_q <= 1'b1;
				end
				CMD_STEP: begin
					if (active_q) begin
						active_q <= !last_n;
					end
					out_valid_q <= active_q;
				end
				default: begin
					out_valid_q <= 1'b0;
				end
			endcase
		end else if (pixels.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Line state and pixel payload
	always_ff @(posedge clk) begin
		if (pop && is_start) begin
			major_q    <= b_ma0;
			end_q      <= b_ma1;
			minor_q    <= b_mi0;
			err_q      <= err0;
			diag_q     <= diag0;
			straight_q <= {1'b0, b_dmin, 1'b0};
			down_q     <= b_cls.minor_down;
			steep_q    <= b_cls.steep;
			colour_q   <= b_colour;
			px_q       <= b_cls.steep ? b_mi0 : b_ma0;
			py_q       <= b_cls.steep ? b_ma0 : b_mi0;
			pc_q       <= b_colour;
			last_q     <= last0;
		end else if (do_step) begin
			major_q <= major_n;
			minor_q <= minor_n;
			err_q   <= err_n;
			px_q    <= steep_q ? minor_n : major_n;
			py_q    <= steep_q ? major_n : minor_n;
			pc_q    <= colour_q;
			last_q  <= last_n;
		end
	end

	assign pixels.valid        = out_valid_q;
	assign pixels.pixel_x      = px_q;
	assign pixels.pixel_y      = py_q;
	assign pixels.pixel_colour = pc_q;
	assign pixels.last_pixel   = last_q;

endmodule

`default_nettype wire

// ===== hdl/bresenham_line_generator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bresenham line rasterizer. A start word (cmd = 0) latches two endpoints and
// a colour and yields the first pixel; each step word (cmd = 1) yields the next
// pixel, with last_pixel set on the final one, and a step with no line in
// progress yields nothing. Pixels ascend along the major axis (x unless the
// line is steeper than 45 degrees). The block takes one word and gives one
// pixel per clock sustained while the pixel side holds ready high; that rate
// is set by the back end's step loop, one error compare and one add per
// pixel. A word passes three registers in order: the front classification
// register loaded at the accepting edge, the QUEUE_DEPTH-entry queue, then
// the output register that presents its pixel.
module bresenham_line_generator_top #(
	parameter int COORD_BITS  = 10,
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	blg_cmd_if.sink   cmds,
	blg_pix_if.source pixels
);
	import blg_pkg::*;

	localparam int QW = $bits(blg_class_t) + 5 * COORD_BITS + COLOUR_BITS;

	logic                   f_valid, f_ready;
	blg_class_t             f_cls, b_cls;
	logic [COORD_BITS-1:0]  f_ma0, f_ma1, f_mi0, f_dmaj, f_dmin;
	logic [COORD_BITS-1:0]  b_ma0, b_ma1, b_mi0, b_dmaj, b_dmin;
	logic [COLOUR_BITS-1:0] f_colour, b_colour;
	logic                   b_valid, b_ready;
	logic [QW-1:0]          q_din, q_dout;

	blg_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmds     (cmds),
		.f_valid  (f_valid),
		.f_ready  (f_ready),
		.f_cls    (f_cls),
		.f_ma0    (f_ma0),
		.f_ma1    (f_ma1),
		.f_mi0    (f_mi0),
		.f_dmaj   (f_dmaj),
		.f_dmin   (f_dmin),
		.f_colour (f_colour)
	);

	assign q_din = {f_cls, f_ma0, f_ma1, f_mi0, f_dmaj, f_dmin, f_colour};

	blg_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (q_din),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_data  (q_dout)
	);

	assign {b_cls, b_ma0, b_ma1, b_mi0, b_dmaj, b_dmin, b_colour} = q_dout;

	blg_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.b_valid  (b_valid),
		.b_ready  (b_ready),
		.b_cls    (b_cls),
		.b_ma0    (b_ma0),
		.b_ma1    (b_ma1),
		.b_mi0    (b_mi0),
		.b_dmaj   (b_dmaj),
		.b_dmin   (b_dmin),
		.b_colour (b_colour),
		.pixels   (pixels)
	);

	// A stalled pixel holds the back end off the queue
	a_back_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(pixels.valid && !pixels.ready) |-> !b_ready)
		else $error("back end advanced while its pixel was stalled");

	// Input stalls only when the front register and the queue are both full
	a_front_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!cmds.ready |-> (f_valid && !f_ready))
		else $error("input stalled with room downstream");

	// Every start word taken by the back end yields a pixel
	a_start_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(b_valid && b_ready && b_cls.kind == CMD_START) |=> pixels.valid)
		else $error("start word gave no pixel");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import blg_pkg::*;

	localparam int CW             = 10;
	localparam int COORD_MAX      = (1 << CW) - 1;
	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 11;
	localparam int RANDOM_WORDS   = 2000;
	localparam int MAX_WAIT       = 14;
	localparam int LONG_HOLD      = 250;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 10;
	localparam int REPORT_LIMIT   = 10;

	// One command word as offered to the rasterizer
	typedef struct {
		cmd_kind_t         kind;
		logic [CW-1:0]     x0;
		logic [CW-1:0]     y0;
		logic [CW-1:0]     x1;
		logic [CW-1:0]     y1;
		logic [COLOUR_BITS-1:0] colour;
	} cmd_word_t;

	// One pixel word as produced by the rasterizer
	typedef struct {
		logic [CW-1:0]          x;
		logic [CW-1:0]          y;
		logic [COLOUR_BITS-1:0] colour;
		logic                   last;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n;

	blg_cmd_if #(.COORD_BITS(CW)) cmds ();
	blg_pix_if #(.COORD_BITS(CW)) pixels ();

	bresenham_line_generator_top #(.COORD_BITS(CW)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmds   (cmds),
		.pixels (pixels)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	cmd_word_t pending_words[$];
	pixel_t    expected_pixels[$];

	int  lines_started;
	int  words_sent;
	int  pixels_checked;
	int  mismatches;
	int  long_holds;
	int  quiet_cycles;
	bit  draining;

	// Idle pattern per side: stretches with no gaps and stretches with random gaps, picked at random
	int stretch_left[2];
	bit stretch_calm[2];

	function automatic int draw_wait(input int side);
		if (stretch_left[side] == 0) begin
			stretch_left[side] = $urandom_range(20, 80);
			stretch_calm[side] = ($urandom_range(0, 2) == 0);
		end
		stretch_left[side]--;
		if (stretch_calm[side])
			return 0;
		return $urandom_range(0, MAX_WAIT);
	endfunction

	// Rasterizer state as tracked by the line predictor
	logic                   trk_active;
	logic [CW-1:0]          trk_major;
	logic [CW-1:0]          trk_major_end;
	logic [CW-1:0]          trk_minor;
	logic signed [12:0]     trk_error;
	logic signed [12:0]     trk_diag;
	logic [11:0]            trk_straight;
	logic                   trk_down;
	logic                   trk_steep;
	logic [COLOUR_BITS-1:0] trk_colour;

	function automatic void push_pixel(input logic last);
		pixel_t p;
		p.x      = trk_steep ? trk_minor : trk_major;
		p.y      = trk_steep ? trk_major : trk_minor;
		p.colour = trk_colour;
		p.last   = last;
		expected_pixels.push_back(p);
	endfunction

	// Advance the tracked line by one accepted word; queue the pixel it yields
	function automatic void predict_line(input cmd_word_t w);
		int            adx, ady, dmaj, dmin;
		logic [CW-1:0] a0, a1, m0, m1, t;
		logic          last;
		if (w.kind == CMD_START) begin
			adx = (w.x1 >= w.x0) ? int'(w.x1) - int'(w.x0) : int'(w.x0) - int'(w.x1);
			ady = (w.y1 >= w.y0) ? int'(w.y1) - int'(w.y0) : int'(w.y0) - int'(w.y1);
			trk_colour = w.colour;
			trk_steep  = (ady > adx);
			if (trk_steep) begin
				a0 = w.y0; a1 = w.y1; m0 = w.x0; m1 = w.x1; dmaj = ady; dmin = adx;
			end else begin
				a0 = w.x0; a1 = w.x1; m0 = w.y0; m1 = w.y1; dmaj = adx; dmin = ady;
			end
			// always walk the major axis upward
			if (a0 > a1) begin
				t = a0; a0 = a1; a1 = t;
				t = m0; m0 = m1; m1 = t;
			end
			trk_major     = a0;
			trk_major_end = a1;
			trk_minor     = m0;
			trk_down      = (m1 < m0);
			trk_error     = 13'(2 * dmin - dmaj);
			trk_diag      = 13'(2 * (dmin - dmaj));
			trk_straight  = 12'(2 * dmin);
			last          = (trk_major == trk_major_end);
			trk_active    = !last;
			lines_started++;
			push_pixel(last);
		end else if (trk_active) begin
			trk_major = trk_major + 1'b1;
			if (!trk_error[12]) begin
				trk_minor = trk_down ? trk_minor - 1'b1 : trk_minor + 1'b1;
				trk_error = trk_error + trk_diag;
			end else begin
				trk_error = trk_error + $signed({1'b0, trk_straight});
			end
			last = (trk_major == trk_major_end);
			if (last)
				trk_active = 1'b0;
			push_pixel(last);
		end
	endfunction

	// Command driver
	cmd_word_t cur_word;
	int        tx_wait;

	always @(posedge clk) begin
		if (!arst_n) begin
			cmds.valid <= 1'b0;
			tx_wait = 0;
		end else begin
			if (cmds.valid && cmds.ready) begin
				predict_line(cur_word);
				words_sent++;
			end
			if (!cmds.valid || cmds.ready) begin
				if (tx_wait != 0) begin
					tx_wait--;
					cmds.valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					cur_word = pending_words.pop_front();
					cmds.cmd     <= cur_word.kind;
					cmds.x_start <= cur_word.x0;
					cmds.y_start <= cur_word.y0;
					cmds.x_end   <= cur_word.x1;
					cmds.y_end   <= cur_word.y1;
					cmds.colour  <= cur_word.colour;
					cmds.valid   <= 1'b1;
					tx_wait = draw_wait(0);
				end else begin
					cmds.valid <= 1'b0;
				end
			end
		end
	end

	// Pixel monitor and checker
	int rx_hold;

	always @(posedge clk) begin
		pixel_t exp_pix;
		if (!arst_n) begin
			pixels.ready <= 1'b0;
			rx_hold = 0;
		end else begin
			if (pixels.valid && pixels.ready) begin
				pixels_checked++;
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("ERROR: unexpected pixel x=%0d y=%0d colour=%0d last=%0b",
							pixels.pixel_x, pixels.pixel_y, pixels.pixel_colour,
							pixels.last_pixel);
				end else begin
					exp_pix = expected_pixels.pop_front();
					if (pixels.pixel_x !== exp_pix.x || pixels.pixel_y !== exp_pix.y ||
						pixels.pixel_colour !== exp_pix.colour ||
						pixels.last_pixel !== exp_pix.last) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("ERROR: pixel %0d expected x=%0d y=%0d colour=%0d last=%0b, got x=%0d y=%0d colour=%0d last=%0b",
								pixels_checked, exp_pix.x, exp_pix.y, exp_pix.colour,
								exp_pix.last, pixels.pixel_x, pixels.pixel_y,
								pixels.pixel_colour, pixels.last_pixel);
					end
				end
				// long backpressure twice in the run so the block fills and stalls its input
				if (pixels_checked == 600 || pixels_checked == 1400) begin
					rx_hold = LONG_HOLD;
					long_holds++;
				end else begin
					rx_hold = draining ? 0 : draw_wait(1);
				end
			end
			if (rx_hold != 0) begin
				rx_hold--;
				pixels.ready <= 1'b0;
			end else begin
				pixels.ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if (!arst_n || (cmds.valid && cmds.ready) || (pixels.valid && pixels.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("ERROR: no progress for %0d cycles, %0d pixels still expected",
				WATCHDOG_LIMIT, expected_pixels.size());
			$display("FAIL bresenham_line_generator_top");
			$finish;
		end
	end

	// Stimulus helpers
	function automatic int line_span(input int x0, y0, x1, y1);
		int adx, ady;
		adx = (x1 > x0) ? x1 - x0 : x0 - x1;
		ady = (y1 > y0) ? y1 - y0 : y0 - y1;
		return (ady > adx) ? ady : adx;
	endfunction

	function automatic logic [CW-1:0] clamp_coord(input int v);
		if (v < 0)
			return '0;
		if (v > COORD_MAX)
			return CW'(COORD_MAX);
		return CW'(v);
	endfunction

	function automatic logic [CW-1:0] rand_coord();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, 1) ? CW'(COORD_MAX) : '0;
		return CW'($urandom_range(0, COORD_MAX));
	endfunction

	task automatic queue_word(input cmd_kind_t kind, input int x0, y0, x1, y1, col);
		cmd_word_t w;
		w.kind   = kind;
		w.x0     = CW'(x0);
		w.y0     = CW'(y0);
		w.x1     = CW'(x1);
		w.y1     = CW'(y1);
		w.colour = COLOUR_BITS'(col);
		pending_words.push_back(w);
	endtask

	// Step word: endpoint and colour fields carry noise that must be ignored
	task automatic queue_step();
		queue_word(CMD_STEP, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
			$urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
			$urandom_range(0, 255));
	endtask

	task automatic queue_line(input int x0, y0, x1, y1, col, steps);
		queue_word(CMD_START, x0, y0, x1, y1, col);
		repeat (steps) queue_step();
	endtask

	// Stimulus, reset and end of run
	initial begin
		int            counted, steps_left, span, n, extra, used, len;
		logic [CW-1:0] sx, sy, ex, ey;
		cmd_kind_t     kind;

		arst_n        = 1'b0;
		cmds.valid    = 1'b0;
		cmds.cmd      = CMD_START;
		cmds.x_start  = '0;
		cmds.y_start  = '0;
		cmds.x_end    = '0;
		cmds.y_end    = '0;
		cmds.colour   = '0;
		pixels.ready  = 1'b0;
		draining      = 1'b0;
		trk_active    = 1'b0;
		trk_major     = '0;
		trk_major_end = '0;
		trk_minor     = '0;
		trk_error     = '0;
		trk_diag      = '0;
		trk_straight  = '0;
		trk_down      = 1'b0;
		trk_steep     = 1'b0;
		trk_colour    = '0;

		// directed: idle step, single points, axis lines, 45 degrees, restart
		queue_step();
		queue_line(0, 0, 0, 0, 0, 0);
		queue_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 255, 0);
		queue_line(COORD_MAX - 3, 5, COORD_MAX, 5, 'h5a, 3);
		queue_line(7, COORD_MAX, 7, COORD_MAX - 3, 'ha5, 3);
		queue_line(0, 3, 3, 0, 'h81, 3);
		queue_line(10, 10, 20, 12, 'h3c, 1);
		queue_line(COORD_MAX, 0, COORD_MAX - 2, 1, 'hc3, 2);
		queue_step();

		// random: mostly complete short lines, some cut short or over-stepped, some noise
		counted    = 0;
		steps_left = 0;
		while (counted < RANDOM_WORDS) begin
			if ($urandom_range(0, 19) == 0) begin
				kind = cmd_kind_t'($urandom_range(0, 1));
				sx = rand_coord(); sy = rand_coord(); ex = rand_coord(); ey = rand_coord();
				queue_word(kind, sx, sy, ex, ey, $urandom_range(0, 255));
				if (kind == CMD_START) begin
					counted++;
					steps_left = line_span(sx, sy, ex, ey);
				end else if (steps_left > 0) begin
					counted++;
					steps_left--;
				end
			end else begin
				len = ($urandom_range(0, 99) == 0) ? COORD_MAX : $urandom_range(0, 16);
				sx  = rand_coord();
				sy  = rand_coord();
				ex  = clamp_coord(int'(sx) + int'($urandom_range(0, 2 * len)) - len);
				ey  = clamp_coord(int'(sy) + int'($urandom_range(0, 2 * len)) - len);
				span  = line_span(sx, sy, ex, ey);
				n     = ($urandom_range(0, 7) == 0) ? $urandom_range(0, span) : span;
				extra = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
				queue_line(sx, sy, ex, ey, $urandom_range(0, 255), n + extra);
				used       = (extra < span - n) ? extra : span - n;
				counted   += 1 + n + used;
				steps_left = span - n - used;
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_words.size() == 0 && !cmds.valid);
		draining = 1'b1;
		wait (expected_pixels.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d words and %0d lines; %0d pixels checked, %0d mismatches",
			words_sent, lines_started, pixels_checked, mismatches);
		$display("Output held off for %0d cycles %0d times while input kept coming",
			LONG_HOLD, long_holds);
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("PASS bresenham_line_generator_top");
		end else begin
			$display("FAIL bresenham_line_generator_top");
		end
		$finish;
	end

endmodule
